>>> rtl/capc_pkg.sv
// ----------------------------------------------------------------------------
// capc_pkg
// shared types, table sizes and request kinds of the card access check
// ----------------------------------------------------------------------------
package capc_pkg;

    // table depths
    localparam int PERMISSION_SLOTS = 64;
    localparam int ZONE_SLOTS       = 16;
    localparam int GROUP_SLOTS      = 32;

    // index widths, at least one bit
    localparam int PERM_AW  = (PERMISSION_SLOTS > 1) ? $clog2(PERMISSION_SLOTS) : 1;
    localparam int ZONE_AW  = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int GROUP_AW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

    // width used to compare a request slot against any table depth
    localparam int SLOT_CW = 9;

    // request kinds
    localparam logic [2:0] KIND_WR_PERM  = 3'd0;
    localparam logic [2:0] KIND_WR_ZONE  = 3'd1;
    localparam logic [2:0] KIND_WR_GROUP = 3'd2;
    localparam logic [2:0] KIND_CHK_FULL = 3'd3;
    localparam logic [2:0] KIND_CHK_CARD = 3'd4;

    // grant causes
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_MATCH = 2'd1;
    localparam logic [1:0] CAUSE_ZONE  = 2'd2;

    // sunday as weekday code zero maps to day seven, bit six
    localparam logic [2:0] SUNDAY_BIT = 3'd6;

    typedef struct packed {
        logic [15:0] card;
        logic [7:0]  facility;
        logic [7:0]  group_id;
        logic [7:0]  zone_id;
    } t_perm;

    typedef struct packed {
        logic [7:0]  zone_id;
        logic [6:0]  days;
        logic [11:0] start_time;
        logic [11:0] end_time;
    } t_zone;

    typedef struct packed {
        logic [7:0] group_id;
        logic [7:0] reader;
    } t_group;

endpackage

>>> rtl/card_access_permission_check.sv
// ----------------------------------------------------------------------------
// card_access_permission_check
// table-based card access check with a sequential scan engine
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------
//  request   | start, busy              | i_kind .. i_now_hhmm
//  result    | o_done (one-cycle pulse) | o_granted, o_grant_cause
//
//  write requests and unused kinds give their result in the cycle after accept
//  and keep the block ready
//  a check visits permission slots in turn, each in a read state and then
//  an evaluate state; a full check also scans reader-group and zone slots
//  that way for each matching record; the single read port of each table
//  reads one slot at a time (address, then registered data)
//  synchronous active-low reset clears all valid bits at once, so no
//  clearing pass: a slot never written reads as all zero
//  the receiver cannot stall: o_done is high for exactly one cycle
//
module card_access_permission_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [5:0]  i_slot,
    input  logic [15:0] i_card_number,
    input  logic [7:0]  i_facility_code,
    input  logic [7:0]  i_reader_group,
    input  logic [7:0]  i_zone,
    input  logic [7:0]  i_door,
    input  logic [6:0]  i_day_mask,
    input  logic [11:0] i_start_time,
    input  logic [11:0] i_end_time,
    input  logic [2:0]  i_weekday,
    input  logic [11:0] i_now_hhmm,
    output logic        o_done,
    output logic        o_granted,
    output logic [1:0]  o_grant_cause
);
    import capc_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREAD = 3'd1;
    localparam logic [2:0] S_PEVAL = 3'd2;
    localparam logic [2:0] S_GREAD = 3'd3;
    localparam logic [2:0] S_GEVAL = 3'd4;
    localparam logic [2:0] S_ZREAD = 3'd5;
    localparam logic [2:0] S_ZEVAL = 3'd6;

    // table storage, no reset: valid bits stand in for the cleared state
    t_perm  perm_mem  [PERMISSION_SLOTS];
    t_zone  zone_mem  [ZONE_SLOTS];
    t_group group_mem [GROUP_SLOTS];

    logic [PERMISSION_SLOTS-1:0] r_pvld, n_pvld;
    logic [ZONE_SLOTS-1:0]       r_zvld, n_zvld;
    logic [GROUP_SLOTS-1:0]      r_gvld, n_gvld;

    // registered read data and its valid bit
    t_perm  r_perm_q;
    t_zone  r_zone_q;
    t_group r_group_q;
    logic   r_perm_v, r_zone_v, r_group_v;

    // sequencer and scan indexes
    logic [2:0]          r_state, n_state;
    logic [PERM_AW-1:0]  r_pidx,  n_pidx;
    logic [ZONE_AW-1:0]  r_zidx,  n_zidx;
    logic [GROUP_AW-1:0] r_gidx,  n_gidx;

    // captured check request
    logic        r_card_only, n_card_only;
    logic [15:0] r_card, n_card;
    logic [7:0]  r_fac, n_fac;
    logic [7:0]  r_door, n_door;
    logic [2:0]  r_daybit, n_daybit;
    logic [11:0] r_now, n_now;

    // record under test in a full check
    logic [7:0] r_rgrp, n_rgrp;
    logic [7:0] r_rzone, n_rzone;

    // result register
    logic       r_done, n_done;
    logic       r_granted, n_granted;
    logic [1:0] r_cause, n_cause;

    logic   accept;
    logic   wr_perm, wr_zone, wr_group;
    t_perm  wd_perm;
    t_zone  wd_zone;
    t_group wd_group;
    t_perm  perm_eff;
    t_zone  zone_eff;
    t_group group_eff;
    logic   perm_match;
    logic   perm_last, zone_last, group_last;
    logic   zone_open;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // table writes happen at accept; out-of-range slots are dropped
    assign wr_perm  = accept && (i_kind == KIND_WR_PERM)
                      && (SLOT_CW'(i_slot) < SLOT_CW'(PERMISSION_SLOTS));
    assign wr_zone  = accept && (i_kind == KIND_WR_ZONE)
                      && (SLOT_CW'(i_slot) < SLOT_CW'(ZONE_SLOTS));
    assign wr_group = accept && (i_kind == KIND_WR_GROUP)
                      && (SLOT_CW'(i_slot) < SLOT_CW'(GROUP_SLOTS));

    assign wd_perm  = '{card: i_card_number, facility: i_facility_code,
                        group_id: i_reader_group, zone_id: i_zone};
    assign wd_zone  = '{zone_id: i_zone, days: i_day_mask,
                        start_time: i_start_time, end_time: i_end_time};
    assign wd_group = '{group_id: i_reader_group, reader: i_door};

    always_ff @(posedge i_clk) begin
        if (wr_perm) begin
            perm_mem[PERM_AW'(i_slot)] <= wd_perm;
        end
        r_perm_q <= perm_mem[r_pidx];
        r_perm_v <= r_pvld[r_pidx];
    end

    always_ff @(posedge i_clk) begin
        if (wr_zone) begin
            zone_mem[ZONE_AW'(i_slot)] <= wd_zone;
        end
        r_zone_q <= zone_mem[r_zidx];
        r_zone_v <= r_zvld[r_zidx];
    end

    always_ff @(posedge i_clk) begin
        if (wr_group) begin
            group_mem[GROUP_AW'(i_slot)] <= wd_group;
        end
        r_group_q <= group_mem[r_gidx];
        r_group_v <= r_gvld[r_gidx];
    end

    // never-written slots read as zero
    assign perm_eff  = r_perm_v  ? r_perm_q  : '0;
    assign zone_eff  = r_zone_v  ? r_zone_q  : '0;
    assign group_eff = r_group_v ? r_group_q : '0;

    assign perm_match = (perm_eff.card == r_card) && (perm_eff.facility == r_fac);
    assign perm_last  = (r_pidx == PERM_AW'(PERMISSION_SLOTS - 1));
    assign zone_last  = (r_zidx == ZONE_AW'(ZONE_SLOTS - 1));
    assign group_last = (r_gidx == GROUP_AW'(GROUP_SLOTS - 1));

    // day bit set and time strictly inside the window
    assign zone_open = zone_eff.days[r_daybit]
                       && (zone_eff.start_time < r_now)
                       && (zone_eff.end_time > r_now);

    always_comb begin
        n_state     = r_state;
        n_pidx      = r_pidx;
        n_zidx      = r_zidx;
        n_gidx      = r_gidx;
        n_card_only = r_card_only;
        n_card      = r_card;
        n_fac       = r_fac;
        n_door      = r_door;
        n_daybit    = r_daybit;
        n_now       = r_now;
        n_rgrp      = r_rgrp;
        n_rzone     = r_rzone;
        n_done      = 1'b0;
        n_granted   = r_granted;
        n_cause     = r_cause;
        n_pvld      = r_pvld;
        n_zvld      = r_zvld;
        n_gvld      = r_gvld;

        if (wr_perm) begin
            n_pvld[PERM_AW'(i_slot)] = 1'b1;
        end
        if (wr_zone) begin
            n_zvld[ZONE_AW'(i_slot)] = 1'b1;
        end
        if (wr_group) begin
            n_gvld[GROUP_AW'(i_slot)] = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_kind == KIND_CHK_FULL) || (i_kind == KIND_CHK_CARD)) begin
                        // capture the check request and start the permission scan
                        n_state     = S_PREAD;
                        n_pidx      = '0;
                        n_card_only = (i_kind == KIND_CHK_CARD);
                        n_card      = i_card_number;
                        n_fac       = i_facility_code;
                        n_door      = i_door;
                        n_now       = i_now_hhmm;
                        n_daybit    = (i_weekday == 3'd0) ? SUNDAY_BIT : (i_weekday - 3'd1);
                    end else begin
                        // writes and unused kinds answer with a denial
                        n_done    = 1'b1;
                        n_granted = 1'b0;
                        n_cause   = CAUSE_NONE;
                    end
                end
            end
            S_PREAD: begin
                n_state = S_PEVAL;
            end
            S_PEVAL: begin
                if (perm_match && (r_card_only
                        || ((perm_eff.group_id == 8'd0) && (perm_eff.zone_id == 8'd0)))) begin
                    // card-only hit or universal record
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_granted = 1'b1;
                    n_cause   = CAUSE_MATCH;
                end else if (perm_match) begin
                    // scheduled record: look for the door in its reader group
                    n_rgrp  = perm_eff.group_id;
                    n_rzone = perm_eff.zone_id;
                    n_gidx  = '0;
                    n_state = S_GREAD;
                end else if (perm_last) begin
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_cause   = CAUSE_NONE;
                end else begin
                    n_pidx  = r_pidx + PERM_AW'(1);
                    n_state = S_PREAD;
                end
            end
            S_GREAD: begin
                n_state = S_GEVAL;
            end
            S_GEVAL: begin
                if ((group_eff.group_id == r_rgrp) && (group_eff.reader == r_door)) begin
                    n_zidx  = '0;
                    n_state = S_ZREAD;
                end else if (!group_last) begin
                    n_gidx  = r_gidx + GROUP_AW'(1);
                    n_state = S_GREAD;
                end else if (perm_last) begin
                    // door not listed and no slots left
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_cause   = CAUSE_NONE;
                end else begin
                    n_pidx  = r_pidx + PERM_AW'(1);
                    n_state = S_PREAD;
                end
            end
            S_ZREAD: begin
                n_state = S_ZEVAL;
            end
            S_ZEVAL: begin
                if ((zone_eff.zone_id == r_rzone) && zone_open) begin
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_granted = 1'b1;
                    n_cause   = CAUSE_ZONE;
                end else if ((zone_eff.zone_id != r_rzone) && !zone_last) begin
                    n_zidx  = r_zidx + ZONE_AW'(1);
                    n_state = S_ZREAD;
                end else if (perm_last) begin
                    // first zone entry closed, or zone missing, on the last slot
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_cause   = CAUSE_NONE;
                end else begin
                    n_pidx  = r_pidx + PERM_AW'(1);
                    n_state = S_PREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_granted <= 1'b0;
            r_cause   <= CAUSE_NONE;
            r_pvld    <= '0;
            r_zvld    <= '0;
            r_gvld    <= '0;
            r_pidx    <= '0;
            r_zidx    <= '0;
            r_gidx    <= '0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_granted <= n_granted;
            r_cause   <= n_cause;
            r_pvld    <= n_pvld;
            r_zvld    <= n_zvld;
            r_gvld    <= n_gvld;
            r_pidx    <= n_pidx;
            r_zidx    <= n_zidx;
            r_gidx    <= n_gidx;
        end
    end

    // request payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_card_only <= n_card_only;
        r_card      <= n_card;
        r_fac       <= n_fac;
        r_door      <= n_door;
        r_daybit    <= n_daybit;
        r_now       <= n_now;
        r_rgrp      <= n_rgrp;
        r_rzone     <= n_rzone;
    end

    assign o_done        = r_done;
    assign o_granted     = r_granted;
    assign o_grant_cause = r_cause;

endmodule

>>> rtl/capc_checker.sv
// ----------------------------------------------------------------------------
// capc_checker
// port-level checks of the card access check, bound to the top level
// ----------------------------------------------------------------------------
module capc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] i_kind,
    input logic       o_done,
    input logic       o_granted,
    input logic [1:0] o_grant_cause
);
    import capc_pkg::*;

    logic is_check;
    assign is_check = (i_kind == KIND_CHK_FULL) || (i_kind == KIND_CHK_CARD);

    // writes and unused kinds answer at once with a denial
    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !is_check |=> o_done && !o_granted && !busy)
        else $error("write request not answered with a denial");

    // a check keeps the block busy and shows no result yet
    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && is_check |=> busy && !o_done)
        else $error("check request did not start a scan");

    // the end of a scan always shows its result
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("scan ended without a result");

    // grant flag and cause agree
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_granted == (o_grant_cause != CAUSE_NONE))
                   && (o_grant_cause != 2'd3))
        else $error("grant flag and cause disagree");

endmodule

bind card_access_permission_check capc_checker u_capc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_kind        (i_kind),
    .o_done        (o_done),
    .o_granted     (o_granted),
    .o_grant_cause (o_grant_cause)
);
